FILE: src/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg: shared constants for the huffman code builder
// Sizes of the symbol set, the node table and the result fields.
// ----------------------------------------------------------------------------
package hcb_pkg;

   // symbol set and node table
   localparam int SYMBOLS    = 8;
   localparam int NODE_COUNT = 2 * SYMBOLS - 1;
   localparam int MERGES     = SYMBOLS - 1;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int SYM_W      = $clog2(SYMBOLS);
   localparam int LOAD_W     = $clog2(SYMBOLS);

   // field widths
   localparam int WEIGHT_W   = 16;
   localparam int SUM_W      = 20;
   localparam int CODE_W     = 7;
   localparam int LEN_W      = 3;
   localparam int INDEX_W    = 3;

endpackage

FILE: src/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder: Huffman code construction over a small symbol set
// Loads one weight per transaction, builds the tree with a shared compare
// unit under a sequencer, then walks each leaf to the root to emit its code.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  --------  -------------------------  ---------------------------------------
//  request   start & !busy              req_symbol_weight
//  response  rsp_strobe (one cycle)     rsp_symbol_index, rsp_code_bits,
//                                       rsp_code_length, rsp_last_code
//
//  a weight that is not the last of a set is stored and the load count advances
//  the last weight starts the build: each merge scans every node below the new
//  node for the two smallest roots (one node a cycle), then merges them
//  each code is then built by walking its leaf up to the root
//  synchronous reset clears the sequencer, the load count and parent marks
//  the receiver cannot stall: every response is shown for exactly one cycle
//
module huffman_code_builder
   import hcb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [WEIGHT_W-1:0]  req_symbol_weight,
   output logic                 rsp_strobe,
   output logic [INDEX_W-1:0]   rsp_symbol_index,
   output logic [CODE_W-1:0]    rsp_code_bits,
   output logic [LEN_W-1:0]     rsp_code_length,
   output logic                 rsp_last_code
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_MERGE,
      ST_WALK
   } state_type;

   state_type             state_ff, state_in;

   // node table
   logic [SUM_W-1:0]      weight_ff     [NODE_COUNT];
   logic [SUM_W-1:0]      weight_in     [NODE_COUNT];
   logic [NODE_W-1:0]     parent_ff     [NODE_COUNT];
   logic [NODE_W-1:0]     parent_in     [NODE_COUNT];
   logic [NODE_COUNT-1:0] has_parent_ff, has_parent_in;
   logic [NODE_W-1:0]     left_ff       [MERGES];
   logic [NODE_W-1:0]     left_in       [MERGES];

   // load and build control
   logic [LOAD_W-1:0]     loaded_ff, loaded_in;
   logic [NODE_W-1:0]     merge_node_ff, merge_node_in;
   logic [NODE_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [SUM_W-1:0]      best_ff, best_in;
   logic [SUM_W-1:0]      second_ff, second_in;
   logic                  best_ok_ff, best_ok_in;
   logic                  second_ok_ff, second_ok_in;
   logic [NODE_W-1:0]     best_idx_ff, best_idx_in;
   logic [NODE_W-1:0]     second_idx_ff, second_idx_in;

   // walk control
   logic [SYM_W-1:0]      walk_sym_ff, walk_sym_in;
   logic [NODE_W-1:0]     walk_node_ff, walk_node_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic [LEN_W-1:0]      len_ff, len_in;

   // response registers
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [CODE_W-1:0]     rsp_code_ff, rsp_code_in;
   logic [LEN_W-1:0]      rsp_len_ff, rsp_len_in;
   logic                  rsp_last_ff, rsp_last_in;

   // shared compare unit and walk datapath
   logic [SUM_W-1:0]      scan_weight;
   logic                  below_best;
   logic                  below_second;
   logic [NODE_W-1:0]     walk_parent;
   logic                  walk_bit;

   assign scan_weight  = weight_ff[scan_idx_ff];
   assign below_best   = !best_ok_ff || (scan_weight < best_ff);
   assign below_second = !second_ok_ff || (scan_weight < second_ff);
   assign walk_parent  = parent_ff[walk_node_ff];
   assign walk_bit     = (left_ff[SYM_W'(walk_parent - NODE_W'(SYMBOLS))] != walk_node_ff);

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      weight_in     = weight_ff;
      parent_in     = parent_ff;
      has_parent_in = has_parent_ff;
      left_in       = left_ff;
      loaded_in     = loaded_ff;
      merge_node_in = merge_node_ff;
      scan_idx_in   = scan_idx_ff;
      best_in       = best_ff;
      second_in     = second_ff;
      best_ok_in    = best_ok_ff;
      second_ok_in  = second_ok_ff;
      best_idx_in   = best_idx_ff;
      second_idx_in = second_idx_ff;
      walk_sym_in   = walk_sym_ff;
      walk_node_in  = walk_node_ff;
      code_in       = code_ff;
      len_in        = len_ff;
      rsp_strobe_in = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (start) begin
               weight_in[NODE_W'(loaded_ff)] = SUM_W'(req_symbol_weight);
               if (loaded_ff == LOAD_W'(SYMBOLS - 1)) begin
                  loaded_in     = '0;
                  merge_node_in = NODE_W'(SYMBOLS);
                  scan_idx_in   = '0;
                  best_ok_in    = 1'b0;
                  second_ok_in  = 1'b0;
                  best_idx_in   = '0;
                  second_idx_in = '0;
                  state_in      = ST_SCAN;
               end else begin
                  loaded_in = loaded_ff + LOAD_W'(1);
               end
            end
         end

         ST_SCAN: begin
            // one node per cycle; each root is checked against the two running minimums
            if (!has_parent_ff[scan_idx_ff]) begin
               if (below_best) begin
                  second_in     = best_ff;
                  second_ok_in  = best_ok_ff;
                  second_idx_in = best_idx_ff;
                  best_in       = scan_weight;
                  best_ok_in    = 1'b1;
                  best_idx_in   = scan_idx_ff;
               end else if (below_second) begin
                  second_in     = scan_weight;
                  second_ok_in  = 1'b1;
                  second_idx_in = scan_idx_ff;
               end
            end
            if (scan_idx_ff == merge_node_ff - NODE_W'(1)) begin
               state_in = ST_MERGE;
            end else begin
               scan_idx_in = scan_idx_ff + NODE_W'(1);
            end
         end

         ST_MERGE: begin
            // new node joins the two smallest roots
            weight_in[merge_node_ff]       = best_ff + second_ff;
            parent_in[best_idx_ff]         = merge_node_ff;
            parent_in[second_idx_ff]       = merge_node_ff;
            has_parent_in[best_idx_ff]     = 1'b1;
            has_parent_in[second_idx_ff]   = 1'b1;
            left_in[SYM_W'(merge_node_ff - NODE_W'(SYMBOLS))] = best_idx_ff;
            if (merge_node_ff == NODE_W'(NODE_COUNT - 1)) begin
               walk_sym_in  = '0;
               walk_node_in = '0;
               code_in      = '0;
               len_in       = '0;
               state_in     = ST_WALK;
            end else begin
               merge_node_in = merge_node_ff + NODE_W'(1);
               scan_idx_in   = '0;
               best_ok_in    = 1'b0;
               second_ok_in  = 1'b0;
               best_idx_in   = '0;
               second_idx_in = '0;
               state_in      = ST_SCAN;
            end
         end

         ST_WALK: begin
            if (has_parent_ff[walk_node_ff]) begin
               // one edge toward the root per cycle
               code_in      = code_ff | (CODE_W'(walk_bit) << len_ff);
               len_in       = len_ff + LEN_W'(1);
               walk_node_in = walk_parent;
            end else begin
               // reached the root: emit this symbol's transaction
               rsp_strobe_in = 1'b1;
               rsp_index_in  = INDEX_W'(walk_sym_ff);
               rsp_code_in   = code_ff;
               rsp_len_in    = len_ff;
               rsp_last_in   = (walk_sym_ff == SYM_W'(SYMBOLS - 1));
               if (walk_sym_ff == SYM_W'(SYMBOLS - 1)) begin
                  has_parent_in = '0;
                  state_in      = ST_LOAD;
               end else begin
                  walk_sym_in  = walk_sym_ff + SYM_W'(1);
                  walk_node_in = NODE_W'(walk_sym_ff + SYM_W'(1));
                  code_in      = '0;
                  len_in       = '0;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      weight_ff     <= weight_in;
      parent_ff     <= parent_in;
      left_ff       <= left_in;
      merge_node_ff <= merge_node_in;
      scan_idx_ff   <= scan_idx_in;
      best_ff       <= best_in;
      second_ff     <= second_in;
      best_idx_ff   <= best_idx_in;
      second_idx_ff <= second_idx_in;
      walk_sym_ff   <= walk_sym_in;
      walk_node_ff  <= walk_node_in;
      code_ff       <= code_in;
      len_ff        <= len_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_LOAD;
         has_parent_ff <= '0;
         loaded_ff     <= '0;
         best_ok_ff    <= 1'b0;
         second_ok_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         has_parent_ff <= has_parent_in;
         loaded_ff     <= loaded_in;
         best_ok_ff    <= best_ok_in;
         second_ok_ff  <= second_ok_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy             = (state_ff != ST_LOAD);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_symbol_index = rsp_index_ff;
   assign rsp_code_bits    = rsp_code_ff;
   assign rsp_code_length  = rsp_len_ff;
   assign rsp_last_code    = rsp_last_ff;

   // responses come only out of the code walk
   a_strobe_from_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_WALK))
      else $error("response strobe outside code walk");

   // every emitted code has at least one bit
   a_code_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_code_length != '0))
      else $error("empty code emitted");

   // the final code frees the block for a new set
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_code) |-> (!busy && (has_parent_ff == '0)))
      else $error("block still busy after final code");

   // a build always ends with every non-root node parented
   a_walk_tree_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && state_in == ST_WALK) |=>
         ($countones(has_parent_ff) == NODE_COUNT - 1))
      else $error("tree incomplete at start of walk");

endmodule
